[rtl/wfq_pkg.sv]
package wfq_pkg;

  // ADC sample width; thresholds are taken in their low SAMPLE_BITS bits
  localparam int SAMPLE_BITS = 12;

  localparam int THR_BITS     = 12;
  localparam int WIN_BITS     = 8;
  localparam int CFG_DATA_BITS = 12;
  localparam int CFG_IDX_BITS  = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_SET_THR   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLR_THR   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SET_CMP   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLR_CMP   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIN_LEN   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HITS_NEED = 3'd5;

  typedef enum logic [1:0] {
    CMP_GE = 2'd0,
    CMP_GT = 2'd1,
    CMP_LE = 2'd2,
    CMP_LT = 2'd3
  } cmp_mode_t;

  // reset values
  localparam logic [THR_BITS-1:0] SET_THR_RST   = 12'd4095;
  localparam logic [THR_BITS-1:0] CLR_THR_RST   = 12'd4095;
  localparam cmp_mode_t           SET_CMP_RST   = CMP_GE;
  localparam cmp_mode_t           CLR_CMP_RST   = CMP_LT;
  localparam logic [WIN_BITS-1:0] WIN_LEN_RST   = 8'd20;
  localparam logic [WIN_BITS-1:0] HITS_NEED_RST = 8'd15;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   enable;
  } in_beat_t;

  typedef struct packed {
    logic fault;
    logic fault_raised;
    logic fault_cleared;
  } out_beat_t;

  // window settings shared by both detectors
  typedef struct packed {
    logic [WIN_BITS-1:0] window_len;
    logic [WIN_BITS-1:0] hits_needed;
  } win_cfg_t;

  function automatic logic hit_test(logic [SAMPLE_BITS-1:0] s,
                                    logic [SAMPLE_BITS-1:0] thr,
                                    cmp_mode_t mode);
    logic hit;
    case (mode)
      CMP_GE:  hit = (s >= thr);
      CMP_GT:  hit = (s > thr);
      CMP_LE:  hit = (s <= thr);
      CMP_LT:  hit = (s < thr);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

[rtl/wfq_window.sv]
// One qualification window: opens on the first hit, counts hits for
// window_len samples, then closes and reports whether enough hits came.
module wfq_window (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              run,
  input  logic              hit,
  input  wfq_pkg::win_cfg_t win_cfg,
  output logic              qualified
);

  logic                         open_r, open_nxt;
  logic [wfq_pkg::WIN_BITS-1:0] count_r, count_nxt;
  logic [wfq_pkg::WIN_BITS-1:0] elapsed_r, elapsed_nxt;

  logic [wfq_pkg::WIN_BITS-1:0] len;
  logic                         open_hit;
  logic [wfq_pkg::WIN_BITS-1:0] count_hit;
  logic [wfq_pkg::WIN_BITS-1:0] elapsed_inc;

  always_comb begin
    // zero length acts as one
    len = (win_cfg.window_len == '0) ? wfq_pkg::WIN_BITS'(1) : win_cfg.window_len;

    open_hit  = open_r | hit;
    // count saturates at the window length
    count_hit = (hit && (count_r < len)) ? count_r + wfq_pkg::WIN_BITS'(1) : count_r;
    elapsed_inc = elapsed_r + wfq_pkg::WIN_BITS'(1);

    open_nxt    = open_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    qualified   = 1'b0;

    if (run) begin
      open_nxt  = open_hit;
      count_nxt = count_hit;
      if (open_hit) begin
        elapsed_nxt = elapsed_inc;
        // wrap to zero also ends the window
        if ((elapsed_inc >= len) || (elapsed_inc == '0)) begin
          qualified   = (count_hit >= win_cfg.hits_needed);
          open_nxt    = 1'b0;
          count_nxt   = '0;
          elapsed_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r    <= 1'b0;
      count_r   <= '0;
      elapsed_r <= '0;
    end else begin
      open_r    <= open_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

[rtl/windowed_fault_qualifier.sv]
// Windowed fault qualifier with hysteresis.
// Input channel (in_valid/in_stall/in_data): one ADC sample per beat with an
// enable bit. A disabled beat still gives a result, but changes no state.
// Result channel (out_valid/out_stall/out_data): one beat per input beat,
// carrying the fault flag after that sample and one-beat raise/clear pulses.
// Configuration (cfg_wr_en/cfg_idx/cfg_wdata): thresholds, compare modes,
// window length and hits needed; write only while no beat is in flight.
// A result is registered and appears in the cycle after its sample is taken.
// Throughput: one sample per cycle unless the result register is stalled;
// the window counters of both detectors update at once, so nothing iterates.
// The result register holds a finished beat while out_stall is high; a new
// sample is still taken in the same cycle that the held beat leaves, and
// in_stall rises only when the result register is full and stalled.
// Reset (rst_n low, synchronous): windows closed, fault low, result register
// empty, registers back to defaults (thresholds 4095, set >=, clear <,
// window 20, hits 15).
module windowed_fault_qualifier (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  wfq_pkg::in_beat_t                   in_data,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output wfq_pkg::out_beat_t                  out_data,
  // configuration
  input  logic                                cfg_wr_en,
  input  logic [wfq_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
  input  logic [wfq_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

  // configuration registers
  logic [wfq_pkg::THR_BITS-1:0] set_thr_r;
  logic [wfq_pkg::THR_BITS-1:0] clr_thr_r;
  wfq_pkg::cmp_mode_t           set_cmp_r;
  wfq_pkg::cmp_mode_t           clr_cmp_r;
  wfq_pkg::win_cfg_t            win_cfg_r;

  logic                         fault_r, fault_nxt;
  logic                         out_valid_r;
  wfq_pkg::out_beat_t           out_r, out_nxt;

  logic                         accept;
  logic                         run_set, run_clr;
  logic                         hit_set, hit_clr;
  logic                         raised, cleared;
  logic                         fault_mid;

  // thresholds only count in their low SAMPLE_BITS bits
  logic [wfq_pkg::SAMPLE_BITS-1:0] set_thr, clr_thr;

  assign set_thr = wfq_pkg::SAMPLE_BITS'(set_thr_r);
  assign clr_thr = wfq_pkg::SAMPLE_BITS'(clr_thr_r);

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign hit_set = wfq_pkg::hit_test(in_data.sample, set_thr, set_cmp_r);
  assign hit_clr = wfq_pkg::hit_test(in_data.sample, clr_thr, clr_cmp_r);

  // set detector runs first; clear detector sees the flag it leaves
  assign run_set   = accept & in_data.enable;
  assign fault_mid = fault_r | raised;
  assign run_clr   = run_set & fault_mid;

  wfq_window u_set_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .run       (run_set),
    .hit       (hit_set),
    .win_cfg   (win_cfg_r),
    .qualified (raised)
  );

  wfq_window u_clr_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .run       (run_clr),
    .hit       (hit_clr),
    .win_cfg   (win_cfg_r),
    .qualified (cleared)
  );

  always_comb begin
    fault_nxt = fault_r;
    if (run_set) begin
      fault_nxt = fault_mid & ~cleared;
    end
    out_nxt.fault         = fault_nxt;
    out_nxt.fault_raised  = raised;
    out_nxt.fault_cleared = cleared;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fault_r <= fault_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_thr_r               <= wfq_pkg::SET_THR_RST;
      clr_thr_r               <= wfq_pkg::CLR_THR_RST;
      set_cmp_r               <= wfq_pkg::SET_CMP_RST;
      clr_cmp_r               <= wfq_pkg::CLR_CMP_RST;
      win_cfg_r.window_len    <= wfq_pkg::WIN_LEN_RST;
      win_cfg_r.hits_needed   <= wfq_pkg::HITS_NEED_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        wfq_pkg::REG_SET_THR:   set_thr_r <= cfg_wdata[wfq_pkg::THR_BITS-1:0];
        wfq_pkg::REG_CLR_THR:   clr_thr_r <= cfg_wdata[wfq_pkg::THR_BITS-1:0];
        wfq_pkg::REG_SET_CMP:   set_cmp_r <= wfq_pkg::cmp_mode_t'(cfg_wdata[1:0]);
        wfq_pkg::REG_CLR_CMP:   clr_cmp_r <= wfq_pkg::cmp_mode_t'(cfg_wdata[1:0]);
        wfq_pkg::REG_WIN_LEN:   win_cfg_r.window_len  <= cfg_wdata[wfq_pkg::WIN_BITS-1:0];
        wfq_pkg::REG_HITS_NEED: win_cfg_r.hits_needed <= cfg_wdata[wfq_pkg::WIN_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

[test/tb_windowed_fault_qualifier.sv]
module tb_windowed_fault_qualifier;
  timeunit 1ns;
  timeprecision 1ps;

  import wfq_pkg::*;

  localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;
  // generous: well above what the slowest run needs
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BEATS = 525;
  localparam int MAX_SHOWN = 10;

  // detector slots in the mirrored window state
  localparam int DET_SET = 0;
  localparam int DET_CLR = 1;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  in_beat_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_beat_t                out_data;
  logic                     cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  windowed_fault_qualifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Directed rows: a register write, a sample checked by the predictor, or a
  // sample whose flags are obvious enough to type in directly.
  typedef enum logic [1:0] {
    ROW_WR,
    ROW_RUN,
    ROW_CHECK
  } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] val;
    in_beat_t                 beat;
    out_beat_t                want;
  } row_t;

  localparam int DIR_ROWS = 40;
  row_t directed [0:DIR_ROWS-1];

  // Mirror of the block's registers
  logic [SAMPLE_BITS-1:0] set_thr, clr_thr;
  cmp_mode_t              set_cmp, clr_cmp;
  logic [WIN_BITS-1:0]    win_len, hits_need;

  // Mirror of the window state, one slot per detector
  logic                fault_up;
  logic                win_open    [2];
  logic [WIN_BITS-1:0] win_hits    [2];
  logic [WIN_BITS-1:0] win_elapsed [2];

  // Flags predicted for accepted samples, oldest first
  out_beat_t pending_flags [$];

  int mismatches;
  int cycle_count;
  int idle_pct;   // sender gap chance per cycle, percent
  int stall_pct;  // receiver stall chance per cycle, percent

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic sample_hits(logic [SAMPLE_BITS-1:0] s,
                                       logic [SAMPLE_BITS-1:0] thr,
                                       cmp_mode_t mode);
    case (mode)
      CMP_GE: return s >= thr;
      CMP_GT: return s > thr;
      CMP_LE: return s <= thr;
      default: return s < thr;
    endcase
  endfunction

  // One sample through one detector's window; 1 when the window closes
  // qualified. A zero length behaves as a one-sample window, and the elapsed
  // counter wrapping to zero also closes the window.
  function automatic logic advance_window(int d, logic hit);
    logic [WIN_BITS-1:0] eff_len;
    logic                qual;
    eff_len = (win_len == '0) ? WIN_BITS'(1) : win_len;
    qual = 1'b0;
    if (hit) begin
      win_open[d] = 1'b1;
      if (win_hits[d] < eff_len) win_hits[d] = win_hits[d] + 1'b1;
    end
    if (win_open[d]) begin
      win_elapsed[d] = win_elapsed[d] + 1'b1;
      if (win_elapsed[d] >= eff_len || win_elapsed[d] == '0) begin
        qual = (win_hits[d] >= hits_need);
        win_elapsed[d] = '0;
        win_hits[d] = '0;
        win_open[d] = 1'b0;
      end
    end
    return qual;
  endfunction

  // Set detector first; the clear detector sees the flag as set left it.
  function automatic out_beat_t qualify_sample(in_beat_t b);
    out_beat_t r;
    r = '0;
    if (b.enable) begin
      r.fault_raised = advance_window(DET_SET, sample_hits(b.sample, set_thr, set_cmp));
      if (r.fault_raised) fault_up = 1'b1;
      if (fault_up) begin
        r.fault_cleared = advance_window(DET_CLR, sample_hits(b.sample, clr_thr, clr_cmp));
        if (r.fault_cleared) fault_up = 1'b0;
      end
    end
    r.fault = fault_up;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers (called at a falling edge, return at a falling edge)
  // ---------------------------------------------------------------------------

  // Offer one beat, with random gaps ahead of it. Expected flags are queued
  // at the edge where the beat is taken.
  task automatic send_sample(in_beat_t b, logic typed, out_beat_t want);
    out_beat_t pred;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
    pred = qualify_sample(b);
    pending_flags.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Stop offering beats and wait until every result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_flags.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      REG_SET_THR:   set_thr = val[SAMPLE_BITS-1:0];
      REG_CLR_THR:   clr_thr = val[SAMPLE_BITS-1:0];
      REG_SET_CMP:   set_cmp = cmp_mode_t'(val[1:0]);
      REG_CLR_CMP:   clr_cmp = cmp_mode_t'(val[1:0]);
      REG_WIN_LEN:   win_len = val[WIN_BITS-1:0];
      REG_HITS_NEED: hits_need = val[WIN_BITS-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------

  // Extremes often, small windows mostly so that windows close and qualify
  // frequently; hits are picked around the same small range.
  function automatic logic [CFG_DATA_BITS-1:0] pick_reg_value(logic [CFG_IDX_BITS-1:0] idx);
    int r;
    int v;
    r = $urandom_range(9);
    case (idx)
      REG_SET_THR, REG_CLR_THR: begin
        if (r == 0) v = 0;
        else if (r == 1) v = SAMPLE_MAX;
        else v = int'($urandom_range(SAMPLE_MAX));
      end
      REG_SET_CMP, REG_CLR_CMP: v = int'($urandom_range(3));
      REG_WIN_LEN: begin
        if (r == 0) v = 0;
        else if (r == 1) v = 255;
        else if (r == 2) v = 1;
        else v = int'($urandom_range(8, 1));
      end
      default: begin
        if (r == 0) v = 0;
        else if (r == 1) v = 255;
        else if (r == 2) v = 1;
        else v = int'($urandom_range(9));
      end
    endcase
    return CFG_DATA_BITS'(v);
  endfunction

  // Rewrite a random subset of registers, at least one, with the block idle.
  task automatic retune_detectors();
    logic written;
    written = 1'b0;
    drain_results();
    for (int i = 0; i <= int'(REG_HITS_NEED); i++) begin
      if ($urandom_range(1) == 1) begin
        write_reg(CFG_IDX_BITS'(i), pick_reg_value(CFG_IDX_BITS'(i)));
        written = 1'b1;
      end
    end
    if (!written) write_reg(REG_WIN_LEN, pick_reg_value(REG_WIN_LEN));
  endtask

  // A sample on the wanted side of a detector's test, often on the boundary.
  function automatic logic [SAMPLE_BITS-1:0] sample_for(logic [SAMPLE_BITS-1:0] thr,
                                                         cmp_mode_t mode,
                                                         logic want_hit);
    int  lo, hi;
    logic upper;
    upper = ((mode == CMP_GE) || (mode == CMP_GT)) == want_hit;
    if (upper) begin
      lo = int'(thr) + (((mode == CMP_GT) || (mode == CMP_LE)) ? 1 : 0);
      hi = SAMPLE_MAX;
    end else begin
      lo = 0;
      hi = int'(thr) - (((mode == CMP_GE) || (mode == CMP_LT)) ? 1 : 0);
    end
    if (lo > hi) return SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
    if ($urandom_range(2) == 0) return SAMPLE_BITS'(upper ? lo : hi);
    return SAMPLE_BITS'($urandom_range(hi, lo));
  endfunction

  // Mostly samples aimed at one detector (three in four hits) so that windows
  // qualify and the fault toggles; the rest are extremes and noise.
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int r;
    r = $urandom_range(99);
    if (r < 40) return sample_for(set_thr, set_cmp, $urandom_range(3) != 0);
    if (r < 80) return sample_for(clr_thr, clr_cmp, $urandom_range(3) != 0);
    if (r < 90) return ($urandom_range(1) == 1) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
    return SAMPLE_BITS'($urandom_range(SAMPLE_MAX));
  endfunction

  // Bursts of samples between register changes.
  task automatic run_phase(int beats);
    int       done;
    in_beat_t b;
    done = 0;
    while (done < beats) begin
      retune_detectors();
      repeat ($urandom_range(80, 20)) begin
        b.enable = ($urandom_range(99) >= 10);
        b.sample = pick_sample();
        send_sample(b, 1'b0, '0);
        done++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------

  function automatic row_t row_wr(logic [CFG_IDX_BITS-1:0] idx, int val);
    row_t r;
    r = '0;
    r.kind = ROW_WR;
    r.idx  = idx;
    r.val  = CFG_DATA_BITS'(val);
    return r;
  endfunction

  function automatic row_t row_run(int s, logic en);
    row_t r;
    r = '0;
    r.kind = ROW_RUN;
    r.beat.sample = SAMPLE_BITS'(s);
    r.beat.enable = en;
    return r;
  endfunction

  function automatic row_t row_chk(int s, logic en, logic f, logic rs, logic cl);
    row_t r;
    r = row_run(s, en);
    r.kind = ROW_CHECK;
    r.want.fault = f;
    r.want.fault_raised = rs;
    r.want.fault_cleared = cl;
    return r;
  endfunction

  initial begin
    directed = '{
      // defaults: no hit on zero, disabled beat is quiet
      row_chk(0, 1'b1, 1'b0, 1'b0, 1'b0),
      row_chk(SAMPLE_MAX, 1'b0, 1'b0, 1'b0, 1'b0),
      // open a 20-sample set window, then shrink it below its elapsed count
      row_run(SAMPLE_MAX, 1'b1),
      row_run('hAAA, 1'b1),
      row_wr(REG_WIN_LEN, 1),
      row_wr(REG_HITS_NEED, 1),
      row_run(SAMPLE_MAX, 1'b1),
      // one-sample windows: raise again while up, then clear on a low sample
      row_chk(SAMPLE_MAX, 1'b1, 1'b1, 1'b1, 1'b0),
      row_chk(0, 1'b1, 1'b0, 1'b0, 1'b1),
      row_chk(0, 1'b0, 1'b0, 1'b0, 1'b0),
      // zero length and zero hits needed
      row_wr(REG_WIN_LEN, 0),
      row_wr(REG_HITS_NEED, 0),
      row_wr(REG_SET_THR, 0),
      row_run(0, 1'b1),
      // strict greater-than around mid scale
      row_wr(REG_SET_CMP, CMP_GT),
      row_wr(REG_SET_THR, 2048),
      row_wr(REG_WIN_LEN, 3),
      row_wr(REG_HITS_NEED, 2),
      row_run(2048, 1'b1),
      row_run(2049, 1'b1),
      row_run(2050, 1'b1),
      row_run(2047, 1'b1),
      // less-or-equal set, greater-or-equal clear against zero
      row_wr(REG_SET_CMP, CMP_LE),
      row_wr(REG_CLR_CMP, CMP_GE),
      row_wr(REG_CLR_THR, 0),
      row_run(2048, 1'b1),
      row_run(0, 1'b1),
      row_run(SAMPLE_MAX, 1'b1),
      // strict less-than set, less-or-equal clear at full scale
      row_wr(REG_SET_CMP, CMP_LT),
      row_wr(REG_CLR_CMP, CMP_LE),
      row_wr(REG_CLR_THR, SAMPLE_MAX),
      row_run(1, 1'b1),
      row_run(2047, 1'b1),
      row_run(SAMPLE_MAX, 1'b1),
      // longest window, most hits; clear test that can never hit
      row_wr(REG_WIN_LEN, 255),
      row_wr(REG_HITS_NEED, 255),
      row_wr(REG_CLR_CMP, CMP_GT),
      row_run(0, 1'b1),
      row_run(SAMPLE_MAX, 1'b0),
      row_run('h555, 1'b1)
    };
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, out_beat_t want, out_beat_t got);
    if (mismatches < MAX_SHOWN)
      $display("%0t %s: expected fault=%b raised=%b cleared=%b, got fault=%b raised=%b cleared=%b",
               $realtime, what, want.fault, want.fault_raised, want.fault_cleared,
               got.fault, got.fault_raised, got.fault_cleared);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_flags.size() == 0) begin
        report_mismatch("unexpected result beat", 'x, out_data);
      end else begin
        want = pending_flags.pop_front();
        if (out_data.fault !== want.fault || out_data.fault_raised !== want.fault_raised ||
            out_data.fault_cleared !== want.fault_cleared)
          report_mismatch("flag mismatch", want, out_data);
      end
    end
  end

  // Receiver backpressure, changed only at the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[windowed_fault_qualifier] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    mismatches = 0;
    idle_pct   = 10;
    stall_pct  = 65;

    // predictor starts from the block's reset state
    set_thr   = SET_THR_RST;
    clr_thr   = CLR_THR_RST;
    set_cmp   = SET_CMP_RST;
    clr_cmp   = CLR_CMP_RST;
    win_len   = WIN_LEN_RST;
    hits_need = HITS_NEED_RST;
    fault_up  = 1'b0;
    for (int d = DET_SET; d <= DET_CLR; d++) begin
      win_open[d]    = 1'b0;
      win_hits[d]    = '0;
      win_elapsed[d] = '0;
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed table; register rows only go in once the pipe is empty
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (directed[i].kind == ROW_WR) begin
        if (i == 0 || directed[i-1].kind != ROW_WR) drain_results();
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        send_sample(directed[i].beat, directed[i].kind == ROW_CHECK, directed[i].want);
      end
    end

    // random: sender light / receiver heavy, then swapped, then no idling
    run_phase(PHASE_BEATS);
    idle_pct  = 65;
    stall_pct = 10;
    run_phase(PHASE_BEATS);
    idle_pct  = 0;
    stall_pct = 0;
    run_phase(PHASE_BEATS);

    drain_results();
    // keep watching the result channel to catch any stray result beat
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending_flags.size() == 0)
      $display("[windowed_fault_qualifier] OK");
    else
      $display("[windowed_fault_qualifier] ERROR");
    $finish;
  end

endmodule
